// ===== design/utat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage accounting table package
// Shared types, command and status codes, guard words and the controller
// state type.
// ----------------------------------------------------------------------------
package utat_pkg;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_HEAD        = 3'd1;
   localparam logic [2:0] ST_FOOT        = 3'd2;
   localparam logic [2:0] ST_TAG_UNDER   = 3'd3;
   localparam logic [2:0] ST_TOTAL_UNDER = 3'd4;
   localparam logic [2:0] ST_FULL        = 3'd5;

   localparam logic [31:0] GUARD_HEAD_A = 32'h497208AB;
   localparam logic [31:0] GUARD_HEAD_B = 32'h127834DC;
   localparam logic [31:0] GUARD_FOOT_A = 32'h023481A9;
   localparam logic [31:0] GUARD_FOOT_B = 32'hFCB87147;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] tag;
      logic [31:0] length;
      logic [31:0] header_first;
      logic [31:0] header_second;
      logic [31:0] footer_first;
      logic [31:0] footer_second;
   } utat_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] tag_current;
      logic [31:0] tag_peak;
      logic [31:0] tag_at_peak;
      logic [31:0] total_current;
      logic [31:0] total_peak;
   } utat_rsp_type;

   typedef enum logic [2:0] {
      UTAT_IDLE,
      UTAT_SEARCH,
      UTAT_FETCH,
      UTAT_UPDATE,
      UTAT_SNAP,
      UTAT_DONE
   } utat_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic search;
      logic fetch;
      logic update;
      logic snap;
   } utat_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic early;
      logic search_done;
      logic full;
      logic need_snap;
      logic snap_done;
   } utat_stat_type;

endpackage

// ===== design/utat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module utat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/utat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage accounting table controller
// Sequences accept, tag search, entry fetch, update, snapshot walk and the
// result strobe.
// ----------------------------------------------------------------------------
module utat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output utat_pkg::utat_cmd_type cmd,
   input  utat_pkg::utat_stat_type stat
);

   utat_pkg::utat_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utat_pkg::UTAT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         utat_pkg::UTAT_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) begin
               state_in = stat.early ? utat_pkg::UTAT_DONE : utat_pkg::UTAT_SEARCH;
            end
         end
         utat_pkg::UTAT_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_done) begin
               state_in = stat.full ? utat_pkg::UTAT_DONE : utat_pkg::UTAT_FETCH;
            end
         end
         utat_pkg::UTAT_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = utat_pkg::UTAT_UPDATE;
         end
         utat_pkg::UTAT_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.need_snap ? utat_pkg::UTAT_SNAP : utat_pkg::UTAT_DONE;
         end
         utat_pkg::UTAT_SNAP: begin
            cmd.snap = 1'b1;
            if (stat.snap_done) begin
               state_in = utat_pkg::UTAT_DONE;
            end
         end
         utat_pkg::UTAT_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = utat_pkg::UTAT_IDLE;
         end
         default: begin
            state_in = utat_pkg::UTAT_IDLE;
         end
      endcase
   end

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not make the block busy");

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block stayed busy after the result beat");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

endmodule

// ===== design/utat_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage accounting table datapath
// Entry RAMs, valid bits, totals, the search and snapshot walk counter and
// the result register.
// ----------------------------------------------------------------------------
module utat_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  utat_pkg::utat_req_type  req_data,
   input  utat_pkg::utat_cmd_type  cmd,
   output utat_pkg::utat_stat_type stat,
   output utat_pkg::utat_rsp_type  rsp_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   // Control state.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        high_ff, high_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic               scan_end_ff, scan_end_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               free_found_ff, free_found_in;

   // Payload.
   logic [1:0]             op_ff, op_in;
   logic [31:0]            tag_ff, tag_in;
   logic [31:0]            len_ff, len_in;
   logic [IW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   hit_ff, hit_in;
   logic                   ins_ff, ins_in;
   utat_pkg::utat_rsp_type rsp_ff, rsp_in;

   // RAM ports.
   logic [31:0]   tag_rd, cur_rd, peak_rd, snap_rd;
   logic          snap_we;
   logic [IW-1:0] snap_waddr, ent_raddr;
   logic [31:0]   snap_wdata;

   // Early checks on the incoming beat.
   logic       head_bad, foot_bad;
   logic [2:0] early_status;

   // Search compare.
   logic match, free_now, last_cmp, search_done;

   // Update arithmetic.
   logic        is_alloc, tag_under, tot_under, need_snap;
   logic [31:0] old_cur, old_peak, old_snap, sum, diff, tot_sum, tot_diff;
   logic [31:0] new_cur, new_peak;

   assign head_bad = (req_data.cmd == utat_pkg::CMD_FREE) &&
                     ((req_data.header_first != utat_pkg::GUARD_HEAD_A) ||
                      (req_data.header_second != utat_pkg::GUARD_HEAD_B));
   assign foot_bad = (req_data.cmd == utat_pkg::CMD_FREE) &&
                     ((req_data.footer_first != utat_pkg::GUARD_FOOT_A) ||
                      (req_data.footer_second != utat_pkg::GUARD_FOOT_B));

   always_comb begin
      if (head_bad) begin
         early_status = utat_pkg::ST_HEAD;
      end else if (foot_bad) begin
         early_status = utat_pkg::ST_FOOT;
      end else begin
         early_status = utat_pkg::ST_OK;
      end
   end

   assign match       = cmp_vld_ff && valid_ff[cmp_idx_ff] && (tag_rd == tag_ff);
   assign free_now    = free_found_ff || (cmp_vld_ff && !valid_ff[cmp_idx_ff]);
   assign last_cmp    = cmp_vld_ff && (cmp_idx_ff == LAST);
   assign search_done = match || last_cmp;

   // A freshly inserted entry starts from zero whatever the RAMs hold.
   assign old_cur  = ins_ff ? 32'd0 : cur_rd;
   assign old_peak = ins_ff ? 32'd0 : peak_rd;
   assign old_snap = ins_ff ? 32'd0 : snap_rd;

   assign is_alloc  = (op_ff == utat_pkg::CMD_ALLOC);
   assign sum       = old_cur + len_ff;
   assign diff      = old_cur - len_ff;
   assign tot_sum   = total_ff + len_ff;
   assign tot_diff  = total_ff - len_ff;
   assign tag_under = len_ff > old_cur;
   assign tot_under = len_ff > total_ff;
   assign need_snap = is_alloc && (high_ff < tot_sum);
   assign new_cur   = is_alloc ? sum : diff;
   assign new_peak  = is_alloc ? ((old_peak < sum) ? sum : old_peak) : old_peak;

   always_comb begin
      stat.early       = !(req_data.cmd inside {utat_pkg::CMD_ALLOC, utat_pkg::CMD_FREE,
                                                utat_pkg::CMD_RELEASE}) ||
                         head_bad || foot_bad;
      stat.search_done = search_done;
      stat.full        = !match && !free_now;
      stat.need_snap   = need_snap;
      stat.snap_done   = last_cmp;
   end

   always_comb begin
      valid_in      = valid_ff;
      total_in      = total_ff;
      high_in       = high_ff;
      scan_in       = scan_ff;
      scan_end_in   = scan_end_ff;
      cmp_vld_in    = cmp_vld_ff;
      free_found_in = free_found_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      len_in        = len_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_idx_in   = free_idx_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      ins_in        = ins_ff;
      rsp_in        = rsp_ff;

      if (cmd.load) begin
         op_in                = req_data.cmd;
         tag_in               = req_data.tag;
         len_in               = req_data.length;
         scan_in              = '0;
         scan_end_in          = 1'b0;
         cmp_vld_in           = 1'b0;
         free_found_in        = 1'b0;
         rsp_in.status        = early_status;
         rsp_in.tag_current   = '0;
         rsp_in.tag_peak      = '0;
         rsp_in.tag_at_peak   = '0;
         rsp_in.total_current = total_ff;
         rsp_in.total_peak    = high_ff;
      end

      // The walk issues one RAM read per cycle; its data is handled in the following cycle.
      if (cmd.search || cmd.snap) begin
         cmp_vld_in = !scan_end_ff;
         cmp_idx_in = scan_ff;
         if (!scan_end_ff) begin
            scan_in     = scan_ff + IW'(1);
            scan_end_in = (scan_ff == LAST);
         end
      end

      if (cmd.search && cmp_vld_ff) begin
         if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (search_done) begin
            hit_in = match;
            ins_in = !match && free_now;
            if (match || !free_found_ff) begin
               idx_in = cmp_idx_ff;
            end else begin
               idx_in = free_idx_ff;
            end
            if (!match && !free_now) begin
               rsp_in.status = utat_pkg::ST_FULL;
            end
         end
      end

      if (cmd.update) begin
         scan_in     = '0;
         scan_end_in = 1'b0;
         cmp_vld_in  = 1'b0;
         if (ins_ff) begin
            valid_in[idx_ff] = 1'b1;
         end
         if (is_alloc) begin
            total_in      = tot_sum;
            rsp_in.status = utat_pkg::ST_OK;
         end else if (tag_under) begin
            rsp_in.status = utat_pkg::ST_TAG_UNDER;
         end else begin
            total_in      = tot_diff;
            rsp_in.status = tot_under ? utat_pkg::ST_TOTAL_UNDER : utat_pkg::ST_OK;
         end
         if (need_snap) begin
            high_in = tot_sum;
         end
         rsp_in.tag_current   = new_cur;
         rsp_in.tag_peak      = new_peak;
         rsp_in.tag_at_peak   = need_snap ? new_cur : old_snap;
         rsp_in.total_current = total_in;
         rsp_in.total_peak    = high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         total_ff      <= '0;
         high_ff       <= '0;
         scan_ff       <= '0;
         scan_end_ff   <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         total_ff      <= total_in;
         high_ff       <= high_in;
         scan_ff       <= scan_in;
         scan_end_ff   <= scan_end_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      len_ff      <= len_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      ins_ff      <= ins_in;
      rsp_ff      <= rsp_in;
   end

   // The snapshot walk reads current counts; otherwise the selected entry is read.
   assign ent_raddr = cmd.snap ? scan_ff : idx_ff;

   always_comb begin
      if (cmd.snap) begin
         snap_we    = cmp_vld_ff;
         snap_waddr = cmp_idx_ff;
         snap_wdata = cur_rd;
      end else begin
         snap_we    = cmd.update && ins_ff;
         snap_waddr = idx_ff;
         snap_wdata = '0;
      end
   end

   utat_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tag_ram (
      .clock (clock),
      .we    (cmd.update && ins_ff),
      .waddr (idx_ff),
      .wdata (tag_ff),
      .raddr (scan_ff),
      .rdata (tag_rd)
   );

   utat_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_cur_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (idx_ff),
      .wdata (new_cur),
      .raddr (ent_raddr),
      .rdata (cur_rd)
   );

   utat_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_peak_ram (
      .clock (clock),
      .we    (cmd.update),
      .waddr (idx_ff),
      .wdata (new_peak),
      .raddr (ent_raddr),
      .rdata (peak_rd)
   );

   utat_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_snap_ram (
      .clock (clock),
      .we    (snap_we),
      .waddr (snap_waddr),
      .wdata (snap_wdata),
      .raddr (ent_raddr),
      .rdata (snap_rd)
   );

   assign rsp_data = rsp_ff;

   a_update_has_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (hit_ff != ins_ff))
      else $error("update without exactly one of hit or insert");

   a_insert_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && ins_ff) |-> !valid_ff[idx_ff])
      else $error("insert into an entry that is already valid");

   a_high_mark_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> (high_ff >= $past(high_ff)))
      else $error("global peak decreased");

endmodule

// ===== design/tagged_usage_accounting_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged usage accounting table
// Per-tag current, peak and snapshot byte counts with a global total and peak.
// ----------------------------------------------------------------------------
// Usage: drive req_data and raise start; the beat is taken at the edge where
// start is high and busy is low. Exactly one result beat follows on rsp_data,
// marked by rsp_strobe for a single cycle; the receiver must take it then.
// One item is in work at a time; busy stays high through the result beat and
// drops in the next cycle, so a new item is taken only after the result beat.
// From accept to result strobe: an unknown command or a failed guard check
// goes straight to the result beat; otherwise the tag search walks the
// entries until the tag is found or the last entry is compared, and a full
// table ends there; else the entry is fetched and updated, and an allocate
// that raises the global peak then walks every entry for the snapshot copy.
// The tag search and the snapshot copy each walk the entry RAMs one entry per
// cycle through a single read port.
// Reset clears all valid bits and both totals; the block can accept a beat
// in the first cycle after reset.
// ----------------------------------------------------------------------------
module tagged_usage_accounting_table #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  utat_pkg::utat_req_type req_data,
   output logic                   rsp_strobe,
   output utat_pkg::utat_rsp_type rsp_data
);

   utat_pkg::utat_cmd_type  cmd;
   utat_pkg::utat_stat_type stat;

   utat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   utat_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/utat_usage_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage accounting table checker
// Watches the request and result channels of the accounting table, keeps its
// own copy of the tag table and totals, predicts each result beat and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module utat_usage_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  utat_pkg::utat_req_type req_data,
   input  logic                   rsp_strobe,
   input  utat_pkg::utat_rsp_type rsp_data,
   output int                     mismatches,
   output int                     outstanding
);

   logic        slot_valid [ENTRIES];
   logic [31:0] slot_tag   [ENTRIES];
   logic [31:0] slot_cur   [ENTRIES];
   logic [31:0] slot_peak  [ENTRIES];
   logic [31:0] slot_snap  [ENTRIES];
   logic [31:0] total_now;
   logic [31:0] total_high;

   utat_pkg::utat_rsp_type pending_results[$];

   // Finds the entry holding tag t, or claims the lowest free one.
   // Returns -1 when the tag is absent and the table has no free entry.
   function automatic int claim_slot(logic [31:0] t);
      int found;
      int spare;
      int i;
      found = -1;
      spare = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            if (found < 0 && slot_tag[i] == t) found = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      if (found >= 0) return found;
      if (spare >= 0) begin
         slot_valid[spare] = 1'b1;
         slot_tag[spare]   = t;
         slot_cur[spare]   = '0;
         slot_peak[spare]  = '0;
         slot_snap[spare]  = '0;
      end
      return spare;
   endfunction

   function automatic utat_pkg::utat_rsp_type account_beat(utat_pkg::utat_req_type r);
      utat_pkg::utat_rsp_type res;
      int                     e;
      int                     i;
      logic [31:0]            prev;
      res        = '0;
      res.status = utat_pkg::ST_OK;
      e          = -1;
      if (r.cmd == utat_pkg::CMD_ALLOC) begin
         e = claim_slot(r.tag);
         if (e < 0) begin
            res.status = utat_pkg::ST_FULL;
         end else begin
            slot_cur[e] = slot_cur[e] + r.length;
            if (slot_peak[e] < slot_cur[e]) slot_peak[e] = slot_cur[e];
            total_now = total_now + r.length;
            // A new global peak captures every live entry's count.
            if (total_high < total_now) begin
               total_high = total_now;
               for (i = 0; i < ENTRIES; i++)
                  if (slot_valid[i]) slot_snap[i] = slot_cur[i];
            end
         end
      end else if (r.cmd inside {utat_pkg::CMD_FREE, utat_pkg::CMD_RELEASE}) begin
         if (r.cmd == utat_pkg::CMD_FREE &&
             (r.header_first != utat_pkg::GUARD_HEAD_A ||
              r.header_second != utat_pkg::GUARD_HEAD_B)) begin
            res.status = utat_pkg::ST_HEAD;
         end else if (r.cmd == utat_pkg::CMD_FREE &&
                      (r.footer_first != utat_pkg::GUARD_FOOT_A ||
                       r.footer_second != utat_pkg::GUARD_FOOT_B)) begin
            res.status = utat_pkg::ST_FOOT;
         end else begin
            e = claim_slot(r.tag);
            if (e < 0) begin
               res.status = utat_pkg::ST_FULL;
            end else begin
               prev        = slot_cur[e];
               slot_cur[e] = prev - r.length;
               if (r.length > prev) begin
                  res.status = utat_pkg::ST_TAG_UNDER;
               end else begin
                  prev      = total_now;
                  total_now = prev - r.length;
                  if (r.length > prev) res.status = utat_pkg::ST_TOTAL_UNDER;
               end
            end
         end
      end
      if (e >= 0) begin
         res.tag_current = slot_cur[e];
         res.tag_peak    = slot_peak[e];
         res.tag_at_peak = slot_snap[e];
      end
      res.total_current = total_now;
      res.total_peak    = total_high;
      return res;
   endfunction

   task automatic check_word(input string label, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      utat_pkg::utat_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
         total_now  = '0;
         total_high = '0;
         pending_results.delete();
      end else begin
         // The result of one beat is checked before the next beat is predicted.
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_word("status", 32'(want.status), 32'(rsp_data.status));
               check_word("tag_current", want.tag_current, rsp_data.tag_current);
               check_word("tag_peak", want.tag_peak, rsp_data.tag_peak);
               check_word("tag_at_peak", want.tag_at_peak, rsp_data.tag_at_peak);
               check_word("total_current", want.total_current, rsp_data.total_current);
               check_word("total_peak", want.total_peak, rsp_data.total_peak);
            end
         end
         if (start && !busy) pending_results.push_back(account_beat(req_data));
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage accounting table testbench
// Drives directed and random allocate, free, release and undefined beats
// into the accounting table, with random gaps, and lets the checker predict
// and compare every result beat. Prints the verdict once all results are in.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          ENTRIES       = 16;
   localparam int          RANDOM_ITEMS  = 1680;
   localparam int          LIMIT_CYCLES  = 400000;
   localparam int          POOL_SIZE     = 24;
   localparam int          HELD_MAX      = 256;
   localparam logic [1:0]  CMD_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] length;
   } held_block_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   utat_pkg::utat_req_type req_data;
   logic                   rsp_strobe;
   utat_pkg::utat_rsp_type rsp_data;
   int                     mismatches;
   int                     outstanding;
   int                     cycle_count;
   bit                     gaps_on;

   logic [31:0]    tag_pool[POOL_SIZE];
   held_block_type held_blocks[$];

   tagged_usage_accounting_table #(.ENTRIES(ENTRIES)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   utat_usage_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic utat_pkg::utat_req_type make_item(logic [1:0] cmd, logic [31:0] tag,
                                                        logic [31:0] length);
      utat_pkg::utat_req_type r;
      r.cmd           = cmd;
      r.tag           = tag;
      r.length        = length;
      r.header_first  = utat_pkg::GUARD_HEAD_A;
      r.header_second = utat_pkg::GUARD_HEAD_B;
      r.footer_first  = utat_pkg::GUARD_FOOT_A;
      r.footer_second = utat_pkg::GUARD_FOOT_B;
      return r;
   endfunction

   // Mostly a small set of tags so that entries are hit again; a few fresh
   // tags keep the table filling up and then hitting the full case.
   function automatic logic [31:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return tag_pool[$urandom_range(0, 13)];
      if (r < 97) return tag_pool[$urandom_range(14, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 80) return $urandom_range(1, 4096);
      if (r < 95) return $urandom_range(4097, 1 << 20);
      return $urandom;
   endfunction

   // Presents one beat, with random gaps first while gaps_on is set, and returns just
   // after the edge that takes it. start stays high so a following beat can go back to back.
   task automatic issue_beat(input utat_pkg::utat_req_type item);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      utat_pkg::utat_req_type item;
      held_block_type         blk;
      int                     r;
      int                     k;
      int                     which;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      gaps_on  = 1'b1;
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
      tag_pool[0] = 32'h0000_0000;
      tag_pool[1] = 32'hFFFF_FFFF;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: field extremes, every command, guard failures,
      // underflows, wrap on allocate and insertion by a free.
      issue_beat(make_item(utat_pkg::CMD_ALLOC, tag_pool[0], 32'd0));
      issue_beat(make_item(utat_pkg::CMD_ALLOC, tag_pool[1], 32'd100));
      issue_beat(make_item(utat_pkg::CMD_ALLOC, tag_pool[0], 32'd50));
      issue_beat(make_item(utat_pkg::CMD_FREE, tag_pool[1], 32'd100));
      item = make_item(utat_pkg::CMD_FREE, tag_pool[0], 32'd1);
      item.header_first = ~utat_pkg::GUARD_HEAD_A;
      issue_beat(item);
      item = make_item(utat_pkg::CMD_FREE, tag_pool[0], 32'd1);
      item.header_second = utat_pkg::GUARD_HEAD_B ^ 32'h8000_0000;
      issue_beat(item);
      item = make_item(utat_pkg::CMD_FREE, tag_pool[0], 32'd1);
      item.footer_first = utat_pkg::GUARD_FOOT_A ^ 32'h0000_0001;
      issue_beat(item);
      item = make_item(utat_pkg::CMD_FREE, tag_pool[0], 32'd1);
      item.footer_second = ~utat_pkg::GUARD_FOOT_B;
      issue_beat(item);
      item = make_item(utat_pkg::CMD_FREE, tag_pool[0], 32'd1);
      item.header_first  = '0;
      item.header_second = '1;
      item.footer_first  = '1;
      item.footer_second = '0;
      issue_beat(item);
      issue_beat(make_item(CMD_UNDEFINED, tag_pool[2], 32'd5));
      issue_beat(make_item(utat_pkg::CMD_RELEASE, tag_pool[0], 32'd51));
      issue_beat(make_item(utat_pkg::CMD_RELEASE, tag_pool[2], 32'd0));
      issue_beat(make_item(utat_pkg::CMD_RELEASE, tag_pool[0], 32'd60));
      issue_beat(make_item(utat_pkg::CMD_ALLOC, tag_pool[0], 32'h0000_0100));
      issue_beat(make_item(utat_pkg::CMD_FREE, tag_pool[2], 32'hFFFF_FFFF));
      item = make_item(utat_pkg::CMD_ALLOC, tag_pool[3], 32'hFFFF_FFFF);
      item.header_first = $urandom;
      item.footer_second = $urandom;
      issue_beat(item);
      item = make_item(utat_pkg::CMD_RELEASE, tag_pool[4], 32'd0);
      item.header_first  = ~utat_pkg::GUARD_HEAD_A;
      item.footer_second = ~utat_pkg::GUARD_FOOT_B;
      issue_beat(item);
      issue_beat(make_item(utat_pkg::CMD_FREE, tag_pool[5], 32'd0));
      issue_beat(make_item(utat_pkg::CMD_ALLOC, tag_pool[5], 32'd1));
      drain_results();

      // Random part: mostly allocations later returned by a free or release
      // of the same tag and length, plus corrupt guards and other noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on = !(n >= 400 && n < 700);
         if (n == RANDOM_ITEMS / 2) drain_results();
         r = $urandom_range(0, 99);
         if (r < 20) begin
            which = $urandom_range(0, 4);
            case (which)
               0: begin
                  item = make_item(utat_pkg::CMD_FREE, pick_tag(), pick_length());
                  k = $urandom_range(0, 3);
                  blk.length = $urandom_range(0, 1) ? $urandom
                                                    : (32'd1 << $urandom_range(0, 31));
                  case (k)
                     0: item.header_first  = utat_pkg::GUARD_HEAD_A ^ blk.length;
                     1: item.header_second = utat_pkg::GUARD_HEAD_B ^ blk.length;
                     2: item.footer_first  = utat_pkg::GUARD_FOOT_A ^ blk.length;
                     default: item.footer_second = utat_pkg::GUARD_FOOT_B ^ blk.length;
                  endcase
                  if (blk.length == '0) item.header_first = ~utat_pkg::GUARD_HEAD_A;
               end
               1: begin
                  item               = make_item(CMD_UNDEFINED, $urandom, $urandom);
                  item.header_first  = $urandom;
                  item.footer_second = $urandom;
               end
               2: item = make_item($urandom_range(0, 1) ? utat_pkg::CMD_FREE
                                                        : utat_pkg::CMD_RELEASE,
                                   pick_tag(), pick_length());
               3: item = make_item(utat_pkg::CMD_ALLOC, $urandom, pick_length());
               default: begin
                  item = make_item(2'($urandom_range(0, 2)), pick_tag(), pick_length());
                  item.header_first  = $urandom;
                  item.header_second = $urandom;
                  item.footer_first  = $urandom;
                  item.footer_second = $urandom;
               end
            endcase
         end else if ((r < 60 || held_blocks.size() == 0) &&
                      held_blocks.size() < HELD_MAX) begin
            blk.tag    = pick_tag();
            blk.length = pick_length();
            held_blocks.push_back(blk);
            item = make_item(utat_pkg::CMD_ALLOC, blk.tag, blk.length);
            item.header_first = $urandom;
         end else begin
            k   = $urandom_range(0, held_blocks.size() - 1);
            blk = held_blocks[k];
            held_blocks.delete(k);
            item = make_item($urandom_range(0, 1) ? utat_pkg::CMD_FREE
                                                  : utat_pkg::CMD_RELEASE,
                             blk.tag, blk.length);
         end
         issue_beat(item);
      end

      drain_results();
      // Let any stray result beat show up before the verdict.
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/utat_pkg.sv
design/utat_ram.sv
design/utat_ctrl.sv
design/utat_dp.sv
design/tagged_usage_accounting_table.sv
tb/utat_usage_checker.sv
tb/testbench.sv
